### rtl/mcct_pkg.sv
// Package of the multi-channel compare timer: sizes, command codes and shared types.
package mcct_pkg;

  // Number of compare channels and width of the free-running counter.
  localparam int CHANNELS   = 3;
  localparam int COUNT_BITS = 16;

  // Fixed widths of the word fields on the two channels.
  localparam int CMD_W      = 2;
  localparam int CHAN_W     = 2;
  localparam int INTERVAL_W = 16;
  localparam int MASK_W     = 3;
  localparam int COUNT_W    = 16;

  typedef logic [COUNT_BITS-1:0] count_t;

  // Command codes; the fourth code is unused and leaves all state alone.
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_t;

  // Control handed from the top level to every compare channel.
  typedef struct packed {
    logic   advance;    // a word is being processed this cycle
    logic   tick;       // the word is a tick
    logic   start;      // the word is a start (channel selection applied separately)
    logic   stop;       // the word is a stop
    logic   periodic;   // reload mode for a start
    count_t count_cur;  // counter before this word
    count_t count_next; // counter after a tick
    count_t interval;   // interval reduced to the counter width
  } chan_ctl_t;

endpackage

### rtl/mcct_if.sv
// Valid/ready channel interfaces for the input and result words of the compare timer.
interface mcct_in_if;
  import mcct_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      cmd;
  logic [CHAN_W-1:0]     channel;
  logic                  periodic;
  logic [INTERVAL_W-1:0] interval;

  modport source (output valid, cmd, channel, periodic, interval, input ready);
  modport sink   (input valid, cmd, channel, periodic, interval, output ready);
endinterface

interface mcct_out_if;
  import mcct_pkg::*;

  logic               valid;
  logic               ready;
  logic [MASK_W-1:0]  fired_mask;
  logic [COUNT_W-1:0] count_now;

  modport source (output valid, fired_mask, count_now, input ready);
  modport sink   (input valid, fired_mask, count_now, output ready);
endinterface

### rtl/mcct_channel.sv
// One compare channel: compare value, reload period, armed and repeat flags.
module mcct_channel
  import mcct_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  chan_ctl_t ctl,
  input  logic      sel,
  output logic      fired
);

  count_t cmp_r, cmp_nxt;
  count_t reload_r, reload_nxt;
  logic   armed_r, armed_nxt;
  logic   repeat_r, repeat_nxt;

  assign fired = ctl.advance && ctl.tick && armed_r && (cmp_r == ctl.count_next);

  always_comb begin
    cmp_nxt    = cmp_r;
    reload_nxt = reload_r;
    armed_nxt  = armed_r;
    repeat_nxt = repeat_r;
    if (fired) begin
      if (repeat_r) begin
        cmp_nxt = cmp_r + reload_r;
      end else begin
        armed_nxt = 1'b0;
      end
    end
    if (ctl.advance && sel && ctl.start) begin
      reload_nxt = ctl.interval;
      repeat_nxt = ctl.periodic;
      cmp_nxt    = ctl.count_cur + ctl.interval;
      armed_nxt  = 1'b1;
    end
    if (ctl.advance && sel && ctl.stop) begin
      armed_nxt  = 1'b0;
      repeat_nxt = 1'b0;
    end
  end

  // The compare value and period are only read while the channel is armed.
  always_ff @(posedge clk) begin
    cmp_r    <= cmp_nxt;
    reload_r <= reload_nxt;
    if (!rst_n) begin
      armed_r  <= 1'b0;
      repeat_r <= 1'b0;
    end else begin
      armed_r  <= armed_nxt;
      repeat_r <= repeat_nxt;
    end
  end

endmodule

### rtl/multi_channel_compare_timer_unit.sv
// Multi-channel compare timer: free-running counter with periodic and one-shot compare channels.
// An accepted input word goes through the input register, then the state update and result
// register, to its result word. Throughput: one word per cycle, limited only by the
// result channel; a tick, start or stop word can follow in every cycle.
// Reset (rst_n low at a clock edge) empties both stages, clears the counter and disarms
// every channel.
module multi_channel_compare_timer_unit
  import mcct_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  mcct_in_if.sink    in_chan,
  mcct_out_if.source out_chan
);

  // Input register stage. A word is held here until the result register can take its
  // result; the timer state is updated at the same edge at which that result is loaded.
  logic                  s1_valid_r;
  logic [CMD_W-1:0]      s1_cmd_r;
  logic [CHAN_W-1:0]     s1_channel_r;
  logic                  s1_periodic_r;
  logic [INTERVAL_W-1:0] s1_interval_r;

  // Result register stage.
  logic               out_valid_r;
  logic [MASK_W-1:0]  out_fired_r;
  logic [COUNT_W-1:0] out_count_r;

  count_t tick_count_r, tick_count_nxt;

  logic            advance;
  logic            in_take;
  chan_ctl_t       ctl;
  logic [CHANNELS-1:0] chan_sel;
  logic [CHANNELS-1:0] fired;

  // The word in the input register moves on whenever the result register is empty or
  // its word is taken in this cycle; the input register then accepts a new word at once.
  assign advance        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !s1_valid_r || advance;
  assign in_take        = in_chan.valid && in_chan.ready;

  // Decode the held word for the channels.
  always_comb begin
    ctl            = '0;
    ctl.advance    = advance;
    ctl.periodic   = s1_periodic_r;
    ctl.count_cur  = tick_count_r;
    ctl.count_next = tick_count_r + count_t'(1);
    ctl.interval   = count_t'(s1_interval_r);
    case (cmd_t'(s1_cmd_r))
      CMD_TICK:  ctl.tick  = 1'b1;
      CMD_START: ctl.start = 1'b1;
      CMD_STOP:  ctl.stop  = 1'b1;
      default:   ctl       = ctl;
    endcase
  end

  // One-hot channel selection; a channel number beyond the last channel selects nothing,
  // so such a start or stop word changes no state.
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      chan_sel[c] = (int'(s1_channel_r) == c);
    end
  end

  assign tick_count_nxt = (advance && ctl.tick) ? ctl.count_next : tick_count_r;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
    mcct_channel u_chan (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .sel   (chan_sel[g]),
      .fired (fired[g])
    );
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r      <= in_chan.cmd;
      s1_channel_r  <= in_chan.channel;
      s1_periodic_r <= in_chan.periodic;
      s1_interval_r <= in_chan.interval;
    end
    if (advance) begin
      out_fired_r <= MASK_W'(fired);
      out_count_r <= COUNT_W'(tick_count_nxt);
    end
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      tick_count_r <= '0;
    end else begin
      tick_count_r <= tick_count_nxt;
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.fired_mask = out_fired_r;
  assign out_chan.count_now  = out_count_r;

endmodule

### sim/tb_multi_channel_compare_timer_unit.sv
// Self-checking testbench of the multi-channel compare timer: directed and random words, checked by a scoreboard.
module tb_multi_channel_compare_timer_unit;
  import mcct_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The fourth command code has no member in the package enum, but the block must still
  // accept it and leave its state alone, so it gets a name of its own here.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // The receiver's long hold-off, during which the sender keeps offering words.
  localparam int HOLD_CYCLES  = 400;
  // Cycles allowed after the last expected result before the verdict.
  localparam int DRAIN_CYCLES = 10;
  // Random words after the directed ones.
  localparam int RANDOM_WORDS = 1880;
  // Watchdog: several times the slowest legal run (about 1900 words, plus the long
  // hold-off).
  localparam longint LIMIT_NS = 64'd2_000_000;

  // One result word as the block should present it.
  typedef struct packed {
    logic [MASK_W-1:0]  fired_mask;
    logic [COUNT_W-1:0] count_now;
  } timer_result_t;

  // Predicts the timer's state and result words, and compares each result with the
  // oldest prediction still outstanding.
  class timer_scoreboard;
    count_t              counter;
    count_t              compare_at [CHANNELS];
    count_t              period     [CHANNELS];
    bit                  armed      [CHANNELS];
    bit                  reloads    [CHANNELS];
    timer_result_t       expected_q [$];
    int unsigned         error_count;

    function new();
      counter     = '0;
      error_count = 0;
      foreach (compare_at[c]) begin
        compare_at[c] = '0;
        period[c]     = '0;
        armed[c]      = 1'b0;
        reloads[c]    = 1'b0;
      end
    endfunction

    // Advances the predicted state by one accepted input word and queues its result.
    function void note_input_word(logic [CMD_W-1:0] cmd, logic [CHAN_W-1:0] chan,
                                  logic per, logic [INTERVAL_W-1:0] ivl);
      timer_result_t res;
      logic [MASK_W-1:0] fired;
      count_t step;
      fired = '0;
      step  = count_t'(ivl);
      case (cmd)
        CMD_TICK: begin
          counter = counter + 1'b1;
          for (int c = 0; c < CHANNELS; c++) begin
            if (armed[c] && compare_at[c] == counter) begin
              fired[c] = 1'b1;
              if (reloads[c]) begin
                compare_at[c] = compare_at[c] + period[c];
              end else begin
                armed[c] = 1'b0;
              end
            end
          end
        end
        CMD_START: begin
          if (int'(chan) < CHANNELS) begin
            period[chan]     = step;
            reloads[chan]    = per;
            compare_at[chan] = counter + step;
            armed[chan]      = 1'b1;
          end
        end
        CMD_STOP: begin
          if (int'(chan) < CHANNELS) begin
            armed[chan]   = 1'b0;
            reloads[chan] = 1'b0;
          end
        end
        default: begin
        end
      endcase
      res.fired_mask = fired;
      res.count_now  = COUNT_W'(counter);
      expected_q.push_back(res);
    endfunction

    // Compares one accepted result word field by field with the oldest prediction.
    function void check_result_word(logic [MASK_W-1:0] mask, logic [COUNT_W-1:0] count);
      timer_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("result word with no prediction waiting: fired_mask %0h count_now %0h",
               mask, count);
        error_count++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (mask !== exp_res.fired_mask) begin
        $error("fired_mask: expected %0h, actual %0h", exp_res.fired_mask, mask);
        error_count++;
      end
      if (count !== exp_res.count_now) begin
        $error("count_now: expected %0h, actual %0h", exp_res.count_now, count);
        error_count++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  mcct_in_if  in_chan_if ();
  mcct_out_if out_chan_if ();

  multi_channel_compare_timer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan_if),
    .out_chan (out_chan_if)
  );

  timer_scoreboard sb = new();

  // Words still to go in the sender's current burst, and the request for the long
  // receiver hold-off that the stimulus raises once.
  int unsigned burst_left   = 0;
  bit          hold_request = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Both monitors sample at the rising edge, before any value driven at that edge has
  // settled, so each handshake is seen exactly as the block saw it.
  always @(posedge clk) begin
    if (rst_n && in_chan_if.valid && in_chan_if.ready) begin
      sb.note_input_word(in_chan_if.cmd, in_chan_if.channel, in_chan_if.periodic,
                         in_chan_if.interval);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan_if.valid && out_chan_if.ready) begin
      sb.check_result_word(out_chan_if.fired_mask, out_chan_if.count_now);
    end
  end

  // Offers one word and returns at the edge at which it is accepted. The sender works
  // in bursts: when a burst is used up, valid drops for a random gap and a new burst
  // length is drawn, now and then a long one so that stretches without idling occur.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [CHAN_W-1:0] chan,
                           input logic per, input logic [INTERVAL_W-1:0] ivl);
    if (burst_left == 0) begin
      in_chan_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    in_chan_if.valid    <= 1'b1;
    in_chan_if.cmd      <= cmd;
    in_chan_if.channel  <= chan;
    in_chan_if.periodic <= per;
    in_chan_if.interval <= ivl;
    do @(posedge clk); while (!in_chan_if.ready);
  endtask

  // Intervals are mostly short so that channels fire often within the random part; a
  // share spans the full field so that every bit of it is exercised.
  function automatic logic [INTERVAL_W-1:0] pick_interval();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      return INTERVAL_W'($urandom_range(0, 12));
    end else if (sel < 8) begin
      return INTERVAL_W'($urandom_range(0, 255));
    end
    return INTERVAL_W'($urandom());
  endfunction

  // A random word: ticks dominate so that armed channels reach their compare values;
  // starts and stops address the spare channel index now and then, and the unused
  // command code appears occasionally. Fields that a command ignores are random too.
  task automatic send_random_word();
    int unsigned sel;
    logic [CMD_W-1:0] cmd;
    logic [CHAN_W-1:0] chan;
    sel  = $urandom_range(0, 99);
    chan = ($urandom_range(0, 9) == 0) ? CHAN_W'(CHANNELS) : CHAN_W'($urandom_range(0, 2));
    if (sel < 58) begin
      cmd = CMD_TICK;
    end else if (sel < 83) begin
      cmd = CMD_START;
    end else if (sel < 95) begin
      cmd = CMD_STOP;
    end else begin
      cmd = CMD_UNUSED;
    end
    send_word(cmd, chan, 1'($urandom()), pick_interval());
  endtask

  // Receiver: cycles through stretches of always ready, random stalls and a fixed
  // two-in-five stall pattern, and honours the one long hold-off when asked.
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned phase;
    out_chan_if.ready <= 1'b0;
    phase = 0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(20, 300);
      repeat (span) begin
        if (hold_request) begin
          out_chan_if.ready <= 1'b0;
          for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
          hold_request = 1'b0;
        end
        case (mode)
          0:       out_chan_if.ready <= 1'b1;
          1:       out_chan_if.ready <= ($urandom_range(0, 2) != 0);
          default: out_chan_if.ready <= (phase % 5 >= 2);
        endcase
        phase++;
        @(posedge clk);
      end
    end
  end

  // Main stimulus: reset, the directed words, the random words, then the drain and the
  // verdict.
  initial begin
    rst_n               <= 1'b0;
    in_chan_if.valid    <= 1'b0;
    in_chan_if.cmd      <= CMD_TICK;
    in_chan_if.channel  <= '0;
    in_chan_if.periodic <= 1'b0;
    in_chan_if.interval <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A plain tick from reset, then channel 0 periodic with a zero interval: it may fire
    // only once the counter has come round its whole range, so it stays silent here.
    send_word(CMD_TICK,  2'd0, 1'b0, 16'h0000);
    send_word(CMD_START, 2'd0, 1'b1, 16'h0000);
    // A one-shot on channel 1 due at the very next tick.
    send_word(CMD_START, 2'd1, 1'b0, 16'h0001);
    send_word(CMD_TICK,  2'd3, 1'b1, 16'hFFFF);
    // Channel 2 periodic with the widest interval, which lands one below the current count.
    send_word(CMD_START, 2'd2, 1'b1, 16'hFFFF);
    // Channel 1 periodic every two ticks, then restarted as a one-shot while still armed.
    send_word(CMD_START, 2'd1, 1'b1, 16'h0002);
    send_word(CMD_TICK,  2'd0, 1'b0, 16'h5555);
    send_word(CMD_TICK,  2'd0, 1'b0, 16'hAAAA);
    send_word(CMD_START, 2'd1, 1'b0, 16'h0003);
    send_word(CMD_STOP,  2'd1, 1'b1, 16'hFFFF);
    send_word(CMD_TICK,  2'd2, 1'b0, 16'h0000);
    // The spare channel index is ignored by start and by stop.
    send_word(CMD_START, 2'd3, 1'b1, 16'h0001);
    send_word(CMD_STOP,  2'd3, 1'b0, 16'h0000);
    send_word(CMD_TICK,  2'd0, 1'b0, 16'h0000);
    // The unused command code must change nothing.
    send_word(CMD_UNUSED, 2'd1, 1'b1, 16'h0001);
    send_word(CMD_UNUSED, 2'd3, 1'b0, 16'hFFFF);
    // Channel 1 reloading every tick fires on each of the following ticks.
    send_word(CMD_START, 2'd1, 1'b1, 16'h0001);
    send_word(CMD_TICK,  2'd1, 1'b1, 16'h8000);
    send_word(CMD_TICK,  2'd1, 1'b0, 16'h7FFF);
    send_word(CMD_TICK,  2'd0, 1'b1, 16'h0000);
    send_word(CMD_STOP,  2'd1, 1'b0, 16'h0000);
    send_word(CMD_TICK,  2'd0, 1'b0, 16'h0000);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // Early on, hold the receiver off for a long while so that the block fills up and
      // must stall its input while the sender keeps offering words.
      if (i == 150) begin
        hold_request = 1'b1;
      end
      send_random_word();
    end

    in_chan_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a lost result word ends the run here.
  initial begin
    #(LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
